// File: rtl/btb_pkg.sv
// Shared types and constants for the branch target buffer.
// Used by btb_update and branch_target_buffer; has no dependencies.

package btb_pkg;

    // Number of entries; must be a power of two (the index is a slice of pc).
    localparam int ENTRIES      = 64;
    localparam int COUNTER_BITS = 2;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int PC_W         = 32;

    localparam logic [COUNTER_BITS-1:0] CTR_HALF = COUNTER_BITS'(1) << (COUNTER_BITS - 1);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX  = {COUNTER_BITS{1'b1}};
    localparam logic [PC_W-1:0]         PC_STEP  = PC_W'(4);

    typedef enum logic [1:0] {
        KIND_LOOKUP    = 2'd0,
        KIND_TAKEN     = 2'd1,
        KIND_NOT_TAKEN = 2'd2
    } t_kind;

    typedef struct packed {
        logic [PC_W-1:0]         tag;
        logic [COUNTER_BITS-1:0] ctr;
        logic [PC_W-1:0]         target;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        tag:    {PC_W{1'b1}},
        ctr:    CTR_HALF,
        target: '0
    };

    // Outcome of one item, from the update logic back to the pipeline.
    typedef struct packed {
        logic            wr_en;
        logic            lookup;
        logic [PC_W-1:0] next_pc;
        t_entry          entry;
    } t_upd;

endpackage

// File: rtl/btb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.

module btb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/btb_update.sv
// Prediction and counter/tag/target update for one entry of the buffer.
// Depends on btb_pkg.

module btb_update (
    input  logic [1:0]                    i_kind,
    input  logic [btb_pkg::PC_W-1:0]      i_pc,
    input  logic [btb_pkg::PC_W-1:0]      i_target,
    input  btb_pkg::t_entry               i_entry,
    output btb_pkg::t_upd                 o_upd
);

    logic hit;

    assign hit = (i_entry.tag == i_pc);

    always_comb begin
        o_upd         = '0;
        o_upd.entry   = i_entry;
        o_upd.next_pc = i_pc + btb_pkg::PC_STEP;
        unique case (btb_pkg::t_kind'(i_kind))
            btb_pkg::KIND_LOOKUP: begin
                o_upd.lookup = 1'b1;
                if (hit && (i_entry.ctr >= btb_pkg::CTR_HALF)) begin
                    o_upd.next_pc = i_entry.target;
                end
            end
            btb_pkg::KIND_TAKEN: begin
                o_upd.wr_en        = 1'b1;
                o_upd.entry.target = i_target;
                if (!hit) begin
                    o_upd.entry.tag = i_pc;
                    o_upd.entry.ctr = btb_pkg::CTR_HALF;
                end else if (i_entry.ctr != btb_pkg::CTR_MAX) begin
                    o_upd.entry.ctr = i_entry.ctr + btb_pkg::COUNTER_BITS'(1);
                end
            end
            btb_pkg::KIND_NOT_TAKEN: begin
                o_upd.wr_en = 1'b1;
                if (!hit) begin
                    o_upd.entry.tag = i_pc;
                    o_upd.entry.ctr = btb_pkg::CTR_HALF;
                end else if (i_entry.ctr != '0) begin
                    o_upd.entry.ctr = i_entry.ctr - btb_pkg::COUNTER_BITS'(1);
                end
            end
            default: begin
                // unused kind code: no state change, no transfer out
            end
        endcase
    end

endmodule

// File: rtl/branch_target_buffer.sv
// Top level of the direct-mapped branch target buffer.
// Depends on btb_pkg, btb_ram and btb_update.

// Two-stage read-modify-write pipeline around one entry RAM (tag, counter,
// target per entry, indexed by pc[IDX_W+1:2]). An item is read from the RAM
// at the edge it is taken. In the following cycle its prediction is formed,
// and at the edge it leaves stage 1 any update is written back and a lookup's
// next_pc is loaded into the output register. One item is taken per cycle
// unless stage 1 is stalled. The only stall is a full output register holding
// an untaken result while another lookup waits in stage 1. Back-to-back
// accesses to the same entry are served by forwarding the most recent write.
// Reset values come from a per-entry valid bit, so no clearing pass is needed.

module branch_target_buffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_kind,
    input  logic [btb_pkg::PC_W-1:0]     i_pc,
    input  logic [btb_pkg::PC_W-1:0]     i_target,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [btb_pkg::PC_W-1:0]     o_next_pc
);

    logic                         in_fire;
    logic                         s1_adv;
    logic                         fwd_hit;
    logic                         wr_en;
    logic [btb_pkg::IDX_W-1:0]    in_idx;
    logic [btb_pkg::ENTRY_W-1:0]  rd_data;
    btb_pkg::t_entry              cur_entry;
    btb_pkg::t_upd                upd;

    logic                         r_s1_valid;
    logic [1:0]                   r_s1_kind;
    logic [btb_pkg::PC_W-1:0]     r_s1_pc;
    logic [btb_pkg::PC_W-1:0]     r_s1_target;
    logic [btb_pkg::IDX_W-1:0]    r_s1_idx;

    logic [btb_pkg::ENTRIES-1:0]  r_vld;
    logic                         r_fwd_valid;
    logic [btb_pkg::IDX_W-1:0]    r_fwd_idx;
    btb_pkg::t_entry              r_fwd_entry;

    logic                         r_out_valid;
    logic [btb_pkg::PC_W-1:0]     r_out_next_pc;

    assign in_idx  = i_pc[btb_pkg::IDX_W+1:2];
    assign s1_adv  = r_s1_valid && (!upd.lookup || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_fire = i_valid && o_ready;
    assign wr_en   = s1_adv && upd.wr_en;

    btb_ram #(
        .WIDTH (btb_pkg::ENTRY_W),
        .DEPTH (btb_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_idx),
        .i_wdata (upd.entry),
        .i_re    (in_fire),
        .i_raddr (in_idx),
        .o_rdata (rd_data)
    );

    // Latest write wins over the RAM copy, which may predate it.
    assign fwd_hit = r_fwd_valid && (r_fwd_idx == r_s1_idx);

    always_comb begin
        priority if (fwd_hit) begin
            cur_entry = r_fwd_entry;
        end else if (r_vld[r_s1_idx]) begin
            cur_entry = btb_pkg::t_entry'(rd_data);
        end else begin
            cur_entry = btb_pkg::ENTRY_RESET;
        end
    end

    btb_update u_update (
        .i_kind   (r_s1_kind),
        .i_pc     (r_s1_pc),
        .i_target (r_s1_target),
        .i_entry  (cur_entry),
        .o_upd    (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_vld       <= '0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vld[r_s1_idx] <= 1'b1;
                r_fwd_valid     <= 1'b1;
            end
            if (s1_adv && upd.lookup) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_kind   <= i_kind;
            r_s1_pc     <= i_pc;
            r_s1_target <= i_target;
            r_s1_idx    <= in_idx;
        end
        if (wr_en) begin
            r_fwd_idx   <= r_s1_idx;
            r_fwd_entry <= upd.entry;
        end
        if (s1_adv && upd.lookup) begin
            r_out_next_pc <= upd.next_pc;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_next_pc = r_out_next_pc;

    a_wr_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s1_valid && !upd.lookup))
        else $error("write-back without an update item in stage 1");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !in_fire)
        else $error("stage 1 overwritten while stalled");

    a_out_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(s1_adv && upd.lookup))
        else $error("result appeared without a lookup");

    a_fwd_valid_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_vld[r_fwd_idx])
        else $error("forwarded entry not marked valid");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for branch_target_buffer: directed cases, random traffic and a long
// output stall, each next_pc checked against a behavioural model of the buffer.
// Depends on btb_pkg and the branch_target_buffer RTL.

module testbench;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         POOL_SIZE    = 24;
    localparam int         MAX_REPORTS  = 10;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     i_valid  = 1'b0;
    logic [1:0]               i_kind   = btb_pkg::KIND_LOOKUP;
    logic [btb_pkg::PC_W-1:0] i_pc     = '0;
    logic [btb_pkg::PC_W-1:0] i_target = '0;
    logic                     i_ready  = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic [btb_pkg::PC_W-1:0] o_next_pc;

    // Model of the buffer contents
    logic [btb_pkg::PC_W-1:0]         model_tag    [btb_pkg::ENTRIES];
    logic [btb_pkg::COUNTER_BITS-1:0] model_ctr    [btb_pkg::ENTRIES];
    logic [btb_pkg::PC_W-1:0]         model_target [btb_pkg::ENTRIES];
    logic [btb_pkg::PC_W-1:0]         next_pc_q    [$];

    // Hot branch addresses, crowded onto a few entries so that tags alias
    logic [btb_pkg::PC_W-1:0] pc_pool [POOL_SIZE];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit tx_gappy       = 1'b0;
    int rx_hold        = 0;
    int rx_stall       = 0;
    int rx_phase_left  = 0;
    bit rx_calm        = 1'b1;

    always #10 i_clk = ~i_clk;

    branch_target_buffer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_pc      (i_pc),
        .i_target  (i_target),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_next_pc (o_next_pc)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return btb_pkg::KIND_LOOKUP;
        if (r < 70) return btb_pkg::KIND_TAKEN;
        if (r < 95) return btb_pkg::KIND_NOT_TAKEN;
        return KIND_IGNORED;
    endfunction

    function automatic logic [btb_pkg::PC_W-1:0] random_pc();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return pc_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 80) return ~btb_pkg::PC_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    task automatic fill_pool();
        logic [btb_pkg::PC_W-1:0] pc;
        foreach (pc_pool[i]) begin
            pc = $urandom;
            pc[btb_pkg::IDX_W+1:2] = btb_pkg::IDX_W'($urandom_range(0, 7));
            pc[1:0] = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b00;
            pc_pool[i] = pc;
        end
        pc_pool[0] = '1;
    endtask

    task automatic reset_model();
        foreach (model_tag[i]) begin
            model_tag[i]    = '1;
            model_ctr[i]    = btb_pkg::CTR_HALF;
            model_target[i] = '0;
        end
    endtask

    // Applies one accepted item to the model; lookups queue their next_pc
    task automatic predict_item(input logic [1:0] kind,
                                input logic [btb_pkg::PC_W-1:0] pc,
                                input logic [btb_pkg::PC_W-1:0] tgt);
        logic [btb_pkg::IDX_W-1:0] idx;
        logic                      hit;
        idx = pc[btb_pkg::IDX_W+1:2];
        hit = (model_tag[idx] == pc);
        if (kind == btb_pkg::KIND_LOOKUP) begin
            if (hit && model_ctr[idx] >= btb_pkg::CTR_HALF)
                next_pc_q.push_back(model_target[idx]);
            else
                next_pc_q.push_back(pc + btb_pkg::PC_STEP);
        end else if (kind == btb_pkg::KIND_TAKEN || kind == btb_pkg::KIND_NOT_TAKEN) begin
            if (!hit) begin
                model_tag[idx] = pc;
                model_ctr[idx] = btb_pkg::CTR_HALF;
            end else if (kind == btb_pkg::KIND_TAKEN) begin
                if (model_ctr[idx] != btb_pkg::CTR_MAX) begin
                    model_ctr[idx] = model_ctr[idx] + btb_pkg::COUNTER_BITS'(1);
                end
            end else begin
                if (model_ctr[idx] != '0) begin
                    model_ctr[idx] = model_ctr[idx] - btb_pkg::COUNTER_BITS'(1);
                end
            end
            if (kind == btb_pkg::KIND_TAKEN) model_target[idx] = tgt;
        end
    endtask

    // Called at a rising edge; returns at the edge the transfer happens
    task automatic send_op(input logic [1:0] kind,
                           input logic [btb_pkg::PC_W-1:0] pc,
                           input logic [btb_pkg::PC_W-1:0] tgt);
        int gap;
        gap = tx_gappy ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_pc     <= pc;
        i_target <= tgt;
        do @(posedge i_clk); while (!o_ready);
        predict_item(kind, pc, tgt);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Back to back, so the same-entry forwarding paths are hit
    task automatic test_directed();
        tx_gappy = 1'b0;
        send_op(btb_pkg::KIND_LOOKUP,    32'hFFFF_FFFF, $urandom);  // reset tag hits
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0000, $urandom);
        send_op(btb_pkg::KIND_LOOKUP,    32'hFFFF_FFFC, $urandom);  // pc + 4 wraps
        send_op(btb_pkg::KIND_TAKEN,     32'h0000_0000, 32'h8000_0000);
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0000, $urandom);
        send_op(btb_pkg::KIND_NOT_TAKEN, 32'h0000_0100, $urandom);  // miss claims, target kept
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_NOT_TAKEN, 32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_NOT_TAKEN, 32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_NOT_TAKEN, 32'h0000_0100, $urandom);  // saturates at zero
        send_op(btb_pkg::KIND_TAKEN,     32'h0000_0100, 32'h0000_1234);
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_TAKEN,     32'h0000_0100, 32'hFFFF_FFFF);
        send_op(btb_pkg::KIND_TAKEN,     32'h0000_0100, 32'hFFFF_FFFF);
        send_op(btb_pkg::KIND_TAKEN,     32'h0000_0100, 32'hFFFF_FFFF); // saturates at max
        send_op(btb_pkg::KIND_NOT_TAKEN, 32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0100, $urandom);
        send_op(KIND_IGNORED,            32'h0000_0200, 32'h1111_1111); // must not claim
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0100, $urandom);
        send_op(btb_pkg::KIND_LOOKUP,    32'h0000_0101, $urandom);  // unaligned, tag differs
        send_op(btb_pkg::KIND_TAKEN,     32'hFFFF_FFFF, 32'h5555_AAAA);
        send_op(btb_pkg::KIND_LOOKUP,    32'hFFFF_FFFF, $urandom);
        send_op(KIND_IGNORED,            32'hFFFF_FFFF, $urandom);
    endtask

    task automatic test_random_traffic(input int items, input bit gappy);
        fill_pool();
        tx_gappy = gappy;
        repeat (items) send_op(random_kind(), random_pc(), $urandom);
    endtask

    // Output held off long enough for the pipeline to back up into the input
    task automatic test_output_stall();
        fill_pool();
        tx_gappy = 1'b0;
        rx_hold  = 300;
        repeat (250) send_op(random_kind(), random_pc(), $urandom);
    endtask

    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_calm       = ($urandom_range(0, 2) == 0);
            rx_phase_left = $urandom_range(50, 400);
        end else begin
            rx_phase_left--;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_next_pc
        logic [btb_pkg::PC_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (next_pc_q.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, next_pc %h", o_next_pc));
            end else begin
                want = next_pc_q.pop_front();
                if (o_next_pc !== want)
                    note_mismatch($sformatf("next_pc expected %h got %h", want, o_next_pc));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(450, 1'b1);
        test_random_traffic(450, 1'b0);
        test_output_stall();
        test_random_traffic(450, 1'b1);
        i_valid <= 1'b0;

        while (next_pc_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && next_pc_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
